// ===== rtl/core/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL package
// Default widths and the code for the channel that holds the maximum.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned RESULT_BITS_DEF  = 16;

  // Which channel is the largest; ties go to red first, then green.
  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_e;

endpackage

// ===== rtl/core/rgbhsl_pix_if.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL pixel channel
// Valid/ready channel that carries one ARGB pixel per word.
// ----------------------------------------------------------------------------
interface rgbhsl_pix_if #(
  parameter int unsigned CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] alpha_in;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, alpha_in, red, green, blue, input ready);
  modport sink   (input valid, alpha_in, red, green, blue, output ready);
endinterface

// ===== rtl/core/rgbhsl_hsl_if.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL result channel
// Valid/ready channel that carries alpha plus hue, saturation and lightness.
// ----------------------------------------------------------------------------
interface rgbhsl_hsl_if #(
  parameter int unsigned CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned RESULT_BITS  = rgbhsl_pkg::RESULT_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] alpha_out;
  logic [RESULT_BITS-1:0]  hue;
  logic [RESULT_BITS-1:0]  saturation;
  logic [RESULT_BITS-1:0]  lightness;

  modport source (output valid, alpha_out, hue, saturation, lightness, input ready);
  modport sink   (input valid, alpha_out, hue, saturation, lightness, output ready);
endinterface

// ===== rtl/core/rgb_to_hsl_convert.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts an ARGB pixel to alpha plus fixed-point hue, saturation, lightness.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output does not stall
// and returns one result word per pixel, in order. A pixel passes
// RESULT_BITS + 2 register stages. The first finds the largest and smallest
// channel. The second forms chroma, sum, the hue numerator and the divisors,
// and gets lightness from the sum by a multiplication with a constant
// reciprocal. After that, two restoring dividers for saturation and hue run
// side by side, each producing one quotient bit per stage. A one-word skid
// register at the output lets the pipeline take one more pixel after the
// output stalls; input ready is a register output. Grey pixels give hue and
// saturation of zero.
module rgb_to_hsl_convert #(
  parameter int unsigned CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned RESULT_BITS  = rgbhsl_pkg::RESULT_BITS_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  rgbhsl_pix_if.sink     pix_i,
  rgbhsl_hsl_if.source   hsl_o
);

  localparam int unsigned CB   = CHANNEL_BITS;
  localparam int unsigned RB   = RESULT_BITS;
  localparam int unsigned SW   = CB + 1;        // width of max + min
  localparam int unsigned DW   = CB + 3;        // divisor width (6 * chroma)
  localparam int unsigned NW   = CB + RB + 3;   // dividend width
  localparam int unsigned NS   = RB + 2;        // pipeline stages
  localparam int unsigned CMAX = (1 << CB) - 1;
  localparam int unsigned LS   = 2 * CB + 2;    // reciprocal shift for lightness
  localparam int unsigned MW   = RB + CB + 2;   // width of the lightness reciprocal

  // Lightness is sum * RMAX / (2 * CMAX); the rounded-up reciprocal with this
  // shift is exact over the whole range of the sum.
  localparam longint unsigned LUM_DIV = (64'd2 << CB) - 64'd2;
  localparam longint unsigned LUM_MUL =
    ((((64'd1 << RB) - 64'd1) << LS) + LUM_DIV - 64'd1) / LUM_DIV;

  typedef struct packed {
    logic [CB-1:0]       alpha;
    logic [CB-1:0]       red;
    logic [CB-1:0]       green;
    logic [CB-1:0]       blue;
    logic [CB-1:0]       mx;
    logic [CB-1:0]       mn;
    rgbhsl_pkg::sector_e sector;
  } ext_t;

  typedef struct packed {
    logic [NW-1:0] x;
    logic [DW-1:0] d;
    logic [RB-1:0] q;
  } div_t;

  typedef struct packed {
    logic [CB-1:0] alpha;
    logic [RB-1:0] lum;
    div_t          sat;
    div_t          hue;
  } pipe_t;

  // One restoring step: tries the divisor shifted to the given quotient bit.
  function automatic div_t div_step(input div_t a, input int unsigned bitpos);
    div_t          r;
    logic [NW-1:0] sh;
    r  = a;
    sh = NW'(a.d) << bitpos;
    if (a.x >= sh) begin
      r.x = a.x - sh;
      r.q = a.q | (RB'(1) << bitpos);
    end
    return r;
  endfunction

  logic          en;
  logic [NS-1:0] v_q;
  ext_t          ext_d, ext_q;
  pipe_t         div_d [RB+1];
  pipe_t         div_q [RB+1];
  pipe_t         skid_q, out_w;
  logic          skid_v_q, skid_v_d;

  // The pipeline moves as a whole while the skid register is empty.
  assign en          = !skid_v_q;
  assign pix_i.ready = en;

  // Stage A: largest and smallest channel.
  always_comb begin
    ext_d.alpha = pix_i.alpha_in;
    ext_d.red   = pix_i.red;
    ext_d.green = pix_i.green;
    ext_d.blue  = pix_i.blue;
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      ext_d.sector = rgbhsl_pkg::SECTOR_RED;
      ext_d.mx     = pix_i.red;
    end else if (pix_i.green >= pix_i.blue) begin
      ext_d.sector = rgbhsl_pkg::SECTOR_GREEN;
      ext_d.mx     = pix_i.green;
    end else begin
      ext_d.sector = rgbhsl_pkg::SECTOR_BLUE;
      ext_d.mx     = pix_i.blue;
    end
    ext_d.mn = pix_i.red;
    if (pix_i.green < ext_d.mn) begin
      ext_d.mn = pix_i.green;
    end
    if (pix_i.blue < ext_d.mn) begin
      ext_d.mn = pix_i.blue;
    end
  end

  // Stage B: chroma, sum, lightness, hue numerator and the divisions set up.
  logic [CB-1:0]    chroma;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    sat_div;
  logic [DW-1:0]    c2, c4, c6, hue_num;
  logic             grey;
  logic [SW+MW-1:0] lum_prod;

  always_comb begin
    chroma   = ext_q.mx - ext_q.mn;
    sum      = SW'(ext_q.mx) + SW'(ext_q.mn);
    grey     = (chroma == '0);
    sat_div  = (sum <= SW'(CMAX)) ? sum : (SW'(2 * CMAX) - sum);
    c2       = DW'(chroma) << 1;
    c4       = DW'(chroma) << 2;
    c6       = c4 + c2;
    lum_prod = (SW+MW)'(sum) * (SW+MW)'(LUM_MUL);
    case (ext_q.sector)
      rgbhsl_pkg::SECTOR_RED: begin
        if (ext_q.green >= ext_q.blue) begin
          hue_num = DW'(ext_q.green) - DW'(ext_q.blue);
        end else begin
          hue_num = c6 - (DW'(ext_q.blue) - DW'(ext_q.green));
        end
      end
      rgbhsl_pkg::SECTOR_GREEN: hue_num = (c2 + DW'(ext_q.blue)) - DW'(ext_q.red);
      rgbhsl_pkg::SECTOR_BLUE:  hue_num = (c4 + DW'(ext_q.red)) - DW'(ext_q.green);
      default:                  hue_num = '0;
    endcase

    div_d[0].alpha = ext_q.alpha;
    div_d[0].lum   = lum_prod[LS +: RB];
    // A grey pixel has zero dividends; a divisor of one keeps the quotients zero.
    div_d[0].sat.x = (NW'(chroma) << RB) - NW'(chroma);
    div_d[0].sat.d = grey ? DW'(1) : DW'(sat_div);
    div_d[0].sat.q = '0;
    div_d[0].hue.x = NW'(hue_num) << RB;
    div_d[0].hue.d = grey ? DW'(1) : c6;
    div_d[0].hue.q = '0;

    // Divider stages: stage k settles quotient bit RB-1-k of both quotients.
    for (int unsigned k = 0; k < RB; k++) begin
      div_d[k+1].alpha = div_q[k].alpha;
      div_d[k+1].lum   = div_q[k].lum;
      div_d[k+1].sat   = div_step(div_q[k].sat, RB - 1 - k);
      div_d[k+1].hue   = div_step(div_q[k].hue, RB - 1 - k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], pix_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ext_q <= ext_d;
      for (int unsigned k = 0; k <= RB; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // Skid register: catches the last stage when the output stalls.
  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      skid_v_d = !hsl_o.ready;
    end else if (v_q[NS-1] && !hsl_o.ready) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_q <= div_q[RB];
    end
  end

  assign out_w            = skid_v_q ? skid_q : div_q[RB];
  assign hsl_o.valid      = skid_v_q || v_q[NS-1];
  assign hsl_o.alpha_out  = out_w.alpha;
  assign hsl_o.hue        = out_w.hue.q;
  assign hsl_o.saturation = out_w.sat.q;
  assign hsl_o.lightness  = out_w.lum;

  // The skid register only ever fills from a valid word that met a stall.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(v_q[NS-1] && !hsl_o.ready))
    else $error("skid register filled without a stalled word");

  // While the skid register is full, the pipeline is frozen.
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(skid_v_q) |-> $stable(v_q) && $stable(div_q[RB]))
    else $error("pipeline moved while the output was stalled");

  // Divisors are never zero, grey pixels included.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (div_q[0].sat.d != '0) && (div_q[0].hue.d != '0))
    else $error("zero divisor entered the divider");

  // Every quotient fits the result width.
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (div_q[0].hue.x < (NW'(div_q[0].hue.d) << RB)) &&
               (div_q[0].sat.x < (NW'(div_q[0].sat.d) << RB)))
    else $error("quotient would overflow the result width");

endmodule
